// ----- rtl/core/asrc_pkg.sv -----
// ----------------------------------------------------------------------------
// asrc_pkg
// Shared types, constants and small arithmetic helpers for the alarm
// set-and-ring controller.
// ----------------------------------------------------------------------------
`default_nettype none

package asrc_pkg;

   // Field widths
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int FIELD_W  = 3;
   localparam int BLINK_W  = 5;
   localparam int LIMIT_W  = 16;

   // Value ranges, carried at minute width so one helper serves both fields
   localparam logic [MINUTE_W-1:0] HOURS       = 6'd24;
   localparam logic [MINUTE_W-1:0] MINUTES     = 6'd60;
   localparam logic [MINUTE_W-1:0] HOUR_MAX    = 6'd23;
   localparam logic [MINUTE_W-1:0] MINUTE_MAX  = 6'd59;
   localparam logic [MINUTE_W-1:0] UNIT_STEP   = 6'd1;
   localparam logic [MINUTE_W-1:0] HOUR_STEP   = 6'd5;
   localparam logic [MINUTE_W-1:0] MINUTE_STEP = 6'd10;

   // Blink phase counter (period 20)
   localparam logic [BLINK_W-1:0] BLINK_LAST  = 5'd19;
   localparam logic [BLINK_W-1:0] BLANK_ABOVE = 5'd15;
   localparam logic [BLINK_W-1:0] FLASH_BELOW = 5'd10;

   localparam logic [LIMIT_W-1:0] RING_LIMIT_RESET = 16'd400;

   // Codes reported on edit_field
   localparam logic [FIELD_W-1:0] FIELD_IDLE   = 3'd0;
   localparam logic [FIELD_W-1:0] FIELD_HOUR   = 3'd1;
   localparam logic [FIELD_W-1:0] FIELD_MINUTE = 3'd2;
   localparam logic [FIELD_W-1:0] FIELD_ONOFF  = 3'd3;
   localparam logic [FIELD_W-1:0] FIELD_BACK   = 3'd4;

   typedef enum logic [4:0] {
      MENU_IDLE   = 5'b00001,
      MENU_HOUR   = 5'b00010,
      MENU_MINUTE = 5'b00100,
      MENU_ONOFF  = 5'b01000,
      MENU_BACK   = 5'b10000
   } menu_state_type;

   typedef enum logic [2:0] {
      RING_INIT    = 3'b001,
      RING_COMPARE = 3'b010,
      RING_ACTIVE  = 3'b100
   } ring_state_type;

   // v + d, wrapped modulo m (v < m, d < m)
   function automatic logic [MINUTE_W-1:0] add_wrap(input logic [MINUTE_W-1:0] v,
                                                   input logic [MINUTE_W-1:0] d,
                                                   input logic [MINUTE_W-1:0] m);
      logic [MINUTE_W:0] s;
      s = {1'b0, v} + {1'b0, d};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[MINUTE_W-1:0];
   endfunction

   // v - d, saturating to maxv on underflow
   function automatic logic [MINUTE_W-1:0] sub_sat(input logic [MINUTE_W-1:0] v,
                                                  input logic [MINUTE_W-1:0] d,
                                                  input logic [MINUTE_W-1:0] maxv);
      return (v < d) ? maxv : (v - d);
   endfunction

   function automatic logic [BLINK_W-1:0] blink_step(input logic [BLINK_W-1:0] p);
      return (p >= BLINK_LAST) ? '0 : (p + 5'd1);
   endfunction

   function automatic logic [FIELD_W-1:0] menu_code(input menu_state_type m);
      logic [FIELD_W-1:0] c;
      case (m)
         MENU_HOUR:   c = FIELD_HOUR;
         MENU_MINUTE: c = FIELD_MINUTE;
         MENU_ONOFF:  c = FIELD_ONOFF;
         MENU_BACK:   c = FIELD_BACK;
         default:     c = FIELD_IDLE;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/asrc_req_if.sv -----
// ----------------------------------------------------------------------------
// asrc_req_if
// Tick channel: key flags and current time, one beat per 10 ms tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface asrc_req_if
   import asrc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                key_ok;
   logic                key_ok_hold;
   logic                key_up;
   logic                key_up_hold;
   logic                key_down;
   logic                key_down_hold;
   logic [HOUR_W-1:0]   cur_hour;
   logic [MINUTE_W-1:0] cur_minute;
   logic [SECOND_W-1:0] cur_second;

   modport source (
      output valid, key_ok, key_ok_hold, key_up, key_up_hold, key_down, key_down_hold,
             cur_hour, cur_minute, cur_second,
      input  ready
   );

   modport sink (
      input  valid, key_ok, key_ok_hold, key_up, key_up_hold, key_down, key_down_hold,
             cur_hour, cur_minute, cur_second,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/core/asrc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// asrc_rsp_if
// Result channel: alarm setting, menu and ring status after each tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface asrc_rsp_if
   import asrc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [HOUR_W-1:0]   wake_hour;
   logic [MINUTE_W-1:0] wake_minute;
   logic                armed;
   logic [FIELD_W-1:0]  edit_field;
   logic                field_blank;
   logic                ringing;
   logic                ring_flash;
   logic                menu_exit;
   logic                pending;

   modport source (
      output valid, wake_hour, wake_minute, armed, edit_field, field_blank, ringing,
             ring_flash, menu_exit, pending,
      input  ready
   );

   modport sink (
      input  valid, wake_hour, wake_minute, armed, edit_field, field_blank, ringing,
             ring_flash, menu_exit, pending,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/core/alarm_set_and_ring_controller_core.sv -----
// ----------------------------------------------------------------------------
// alarm_set_and_ring_controller_core
// One tick beat (10 ms) in, one status beat out. Each tick runs the set-up
// menu first (OK enters hour -> minute -> on/off -> back prompt; UP/DOWN step
// by 1, held UP/DOWN by 5 hours or 10 minutes; upward steps wrap modulo,
// downward steps below zero saturate to 23 or 59; held OK leaves the menu),
// then the alarm step (pending when time matches with second 0, alarm on and
// compare enabled; ringing ring_limit+1 ticks or until UP). A tick beat is
// taken every clock cycle: the whole update is one combinational pass from
// the state registers into the state and result registers; the result beat
// follows in the next cycle. The result register frees up as it is read, so
// req_if.ready only drops while a result is stalled. The user must write
// ring_limit via csr_wr_en/csr_wr_data only while idle; no check in the block.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_set_and_ring_controller_core
   import asrc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   asrc_req_if.sink                req_if,
   asrc_rsp_if.source              rsp_if,
   input  wire logic               csr_wr_en,
   input  wire logic [LIMIT_W-1:0] csr_wr_data
);

   // ---------------------------------------------------------------------
   // Handshake: accept whenever the result register is empty or draining
   // ---------------------------------------------------------------------
   logic rsp_valid_ff;
   logic req_accept;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   logic [LIMIT_W-1:0]  ring_limit_ff;
   menu_state_type      menu_ff,       menu_in;
   logic [HOUR_W-1:0]   hour_ff,       hour_in;
   logic [MINUTE_W-1:0] minute_ff,     minute_in;
   logic                on_ff,         on_in;
   logic                cmp_en_ff,     cmp_en_in;
   logic [BLINK_W-1:0]  edit_blink_ff, edit_blink_in;
   ring_state_type      ring_ff,       ring_in;
   logic                pending_ff,    pending_in;
   logic [LIMIT_W-1:0]  ring_ticks_ff, ring_ticks_in;
   logic [BLINK_W-1:0]  ring_blink_ff, ring_blink_in;

   // Per-tick flags headed for the result register
   logic blank_in, ringing_in, flash_in, exit_in;

   // ---------------------------------------------------------------------
   // Tick update: menu step, then alarm step (alarm sees the menu's result)
   // ---------------------------------------------------------------------
   always_comb begin
      logic [MINUTE_W-1:0] h;
      logic [MINUTE_W-1:0] m;
      logic [LIMIT_W:0]    next_ticks;
      logic                time_match;

      menu_in       = menu_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      on_in         = on_ff;
      cmp_en_in     = cmp_en_ff;
      edit_blink_in = edit_blink_ff;
      ring_in       = ring_ff;
      pending_in    = pending_ff;
      ring_ticks_in = ring_ticks_ff;
      ring_blink_in = ring_blink_ff;
      blank_in      = 1'b0;
      ringing_in    = 1'b0;
      flash_in      = 1'b0;
      exit_in       = 1'b0;

      // Hour chain: up, up-hold, down, down-hold applied in that order
      h = {1'b0, hour_ff};
      if (req_if.key_up)        h = add_wrap(h, UNIT_STEP, HOURS);
      if (req_if.key_up_hold)   h = add_wrap(h, HOUR_STEP, HOURS);
      if (req_if.key_down)      h = sub_sat(h, UNIT_STEP, HOUR_MAX);
      if (req_if.key_down_hold) h = sub_sat(h, HOUR_STEP, HOUR_MAX);

      m = minute_ff;
      if (req_if.key_up)        m = add_wrap(m, UNIT_STEP, MINUTES);
      if (req_if.key_up_hold)   m = add_wrap(m, MINUTE_STEP, MINUTES);
      if (req_if.key_down)      m = sub_sat(m, UNIT_STEP, MINUTE_MAX);
      if (req_if.key_down_hold) m = sub_sat(m, MINUTE_STEP, MINUTE_MAX);

      // ---- set-up menu ----
      case (menu_ff)
         MENU_IDLE: begin
            if (req_if.key_ok && cmp_en_ff) menu_in = MENU_HOUR;
         end
         MENU_HOUR, MENU_MINUTE, MENU_ONOFF, MENU_BACK: begin
            cmp_en_in     = 1'b0;
            edit_blink_in = blink_step(edit_blink_ff);
            blank_in      = edit_blink_in > BLANK_ABOVE;

            if (menu_ff == MENU_HOUR)   hour_in   = h[HOUR_W-1:0];
            if (menu_ff == MENU_MINUTE) minute_in = m;
            // UP and DOWN together toggle twice
            if (menu_ff == MENU_ONOFF)  on_in = on_ff ^ req_if.key_up ^ req_if.key_down;

            if (menu_ff == MENU_BACK) begin
               if (req_if.key_up || req_if.key_down || req_if.key_ok) begin
                  menu_in   = MENU_IDLE;
                  cmp_en_in = 1'b1;
               end
               exit_in = req_if.key_ok;
            end else begin
               if (req_if.key_ok) begin
                  case (menu_ff)
                     MENU_HOUR:   menu_in = MENU_MINUTE;
                     MENU_MINUTE: menu_in = MENU_ONOFF;
                     default:     menu_in = MENU_BACK;
                  endcase
               end
               // held OK wins over plain OK
               if (req_if.key_ok_hold) begin
                  menu_in   = MENU_IDLE;
                  cmp_en_in = 1'b1;
               end
            end
         end
         default: ;
      endcase

      // ---- alarm step ----
      time_match = (req_if.cur_hour == hour_in) && (req_if.cur_minute == minute_in) &&
                   (req_if.cur_second == '0);
      next_ticks = {1'b0, ring_ticks_ff} + {{LIMIT_W{1'b0}}, 1'b1};

      case (ring_ff)
         RING_COMPARE: begin
            if (time_match && on_in && cmp_en_in) pending_in = 1'b1;
            if (pending_in) ring_in = RING_ACTIVE;
         end
         RING_ACTIVE: begin
            ringing_in    = 1'b1;
            cmp_en_in     = 1'b0;
            ring_blink_in = blink_step(ring_blink_ff);
            flash_in      = ring_blink_in < FLASH_BELOW;
            if ((next_ticks > {1'b0, ring_limit_ff}) || req_if.key_up) begin
               cmp_en_in     = 1'b1;
               pending_in    = 1'b0;
               ring_ticks_in = '0;
               ring_in       = RING_INIT;
            end else begin
               ring_ticks_in = next_ticks[LIMIT_W-1:0];
            end
         end
         default: ring_in = RING_COMPARE;
      endcase
   end

   // ---------------------------------------------------------------------
   // State registers, advanced once per accepted tick beat
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_limit_ff <= RING_LIMIT_RESET;
         menu_ff       <= MENU_IDLE;
         hour_ff       <= '0;
         minute_ff     <= '0;
         on_ff         <= 1'b0;
         cmp_en_ff     <= 1'b1;
         edit_blink_ff <= '0;
         ring_ff       <= RING_INIT;
         pending_ff    <= 1'b0;
         ring_ticks_ff <= '0;
         ring_blink_ff <= '0;
      end else begin
         if (csr_wr_en) ring_limit_ff <= csr_wr_data;
         if (req_accept) begin
            menu_ff       <= menu_in;
            hour_ff       <= hour_in;
            minute_ff     <= minute_in;
            on_ff         <= on_in;
            cmp_en_ff     <= cmp_en_in;
            edit_blink_ff <= edit_blink_in;
            ring_ff       <= ring_in;
            pending_ff    <= pending_in;
            ring_ticks_ff <= ring_ticks_in;
            ring_blink_ff <= ring_blink_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   logic [HOUR_W-1:0]   wake_hour_ff;
   logic [MINUTE_W-1:0] wake_minute_ff;
   logic                armed_ff;
   logic [FIELD_W-1:0]  edit_field_ff;
   logic                field_blank_ff;
   logic                ringing_ff;
   logic                ring_flash_ff;
   logic                menu_exit_ff;
   logic                pending_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         wake_hour_ff   <= hour_in;
         wake_minute_ff <= minute_in;
         armed_ff       <= on_in;
         edit_field_ff  <= menu_code(menu_in);
         field_blank_ff <= blank_in;
         ringing_ff     <= ringing_in;
         ring_flash_ff  <= flash_in;
         menu_exit_ff   <= exit_in;
         pending_out_ff <= pending_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.wake_hour   = wake_hour_ff;
   assign rsp_if.wake_minute = wake_minute_ff;
   assign rsp_if.armed       = armed_ff;
   assign rsp_if.edit_field  = edit_field_ff;
   assign rsp_if.field_blank = field_blank_ff;
   assign rsp_if.ringing     = ringing_ff;
   assign rsp_if.ring_flash  = ring_flash_ff;
   assign rsp_if.menu_exit   = menu_exit_ff;
   assign rsp_if.pending     = pending_out_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // every accepted tick yields a result beat next cycle
   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted tick produced no result beat");

   // alarm hour stays in range
   a_hour_range: assert property (@(posedge clock) disable iff (reset)
      hour_ff < HOURS[HOUR_W-1:0])
      else $error("alarm hour out of range");

   // flash only while ringing
   a_flash_ringing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ring_flash_ff) |-> ringing_ff)
      else $error("ring flash without ringing");

   // an exit pulse leaves the menu idle
   a_exit_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && menu_exit_ff) |-> (edit_field_ff == FIELD_IDLE))
      else $error("menu exit with menu still open");

endmodule

`default_nettype wire
